### hdl/lca_binary_lifting_assert.svh
// assertion macros for the lowest common ancestor engine
// used by the top level only, no other dependencies
`ifndef LCA_BINARY_LIFTING_ASSERT_SVH
`define LCA_BINARY_LIFTING_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lca_binary_lifting: assertion failed");

// next-cycle implication, disabled during reset
`define LCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lca_binary_lifting: assertion failed");

`endif

### hdl/lca_pkg.sv
// shared types, constants and helpers of the lowest common ancestor engine
// no dependencies; imported by every module of the block but lca_ram
package lca_pkg;

   // sizing
   localparam int NODES      = 1024;
   localparam int LEVELS     = 10;
   localparam int FIELD_W    = 10;
   localparam int FUNC_W     = 2;
   localparam int NODE_AW    = $clog2(NODES);
   localparam int TAB_DEPTH  = NODES * LEVELS;
   localparam int TAB_AW     = $clog2(TAB_DEPTH);
   localparam int LVL_W      = $clog2(LEVELS);
   localparam int DIFF_W     = FIELD_W + 2;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef logic [FIELD_W-1:0] node_type;
   typedef logic [LVL_W-1:0]   lvl_type;

   localparam node_type               NODE_COUNT_RESET = FIELD_W'(1023);
   localparam logic [TAB_AW-1:0]      TAB_LAST         = TAB_AW'(TAB_DEPTH - 1);
   localparam lvl_type                LVL_TOP          = LVL_W'(LEVELS - 1);

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   // classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_BUILD,
      OP_QUERY
   } op_type;

   // queued command: load uses node/parent/depth, query uses a/b in f0/f1
   typedef struct packed {
      op_type   op;
      node_type f0;
      node_type f1;
      node_type f2;
   } cmd_type;

   // back-end status seen by the front
   typedef struct packed {
      logic clearing;
   } stat_type;

   // back-end sequencer states
   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_B_RD0,
      S_B_RD1,
      S_B_WR,
      S_Q_DA,
      S_Q_DB,
      S_Q_SWAP,
      S_L_CHK,
      S_L_UP,
      S_L_DEP,
      S_L_END,
      S_M_RA,
      S_M_RB,
      S_M_CMP,
      S_M_FIN,
      S_M_RES,
      S_Q_OUT
   } state_type;

   // node lies inside the stores
   function automatic logic node_ok(input node_type n);
      return (32'(n) < 32'(NODES));
   endfunction

   // ancestor table address of level j of node n
   function automatic logic [TAB_AW-1:0] tab_addr(input node_type n, input lvl_type j);
      logic [31:0] full;
      full = 32'(n) * 32'(LEVELS) + 32'(j);
      return full[TAB_AW-1:0];
   endfunction

   // depth store address of node n
   function automatic logic [NODE_AW-1:0] depth_addr(input node_type n);
      logic [31:0] full;
      full = 32'(n);
      return full[NODE_AW-1:0];
   endfunction

   // highest node covered by a build
   function automatic node_type build_last(input node_type nc);
      if (32'(nc) > 32'(NODES - 1)) begin
         return FIELD_W'(NODES - 1);
      end
      return nc;
   endfunction

endpackage

### hdl/lca_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lca_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/lca_fifo.sv
// short command queue between front and back
// depends on lca_pkg
module lca_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lca_pkg::cmd_type push_data,
   input  logic             pop,
   output lca_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import lca_pkg::*;

   cmd_type              entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + FIFO_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign full  = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign empty = (count_ff == '0);

endmodule

### hdl/lca_front.sv
// front end: accepts request transactions and classifies them into commands
// depends on lca_pkg; feeds lca_fifo
module lca_front (
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lca_pkg::FUNC_W-1:0]      req_func,
   input  lca_pkg::node_type               req_node,
   input  lca_pkg::node_type               req_parent_node,
   input  lca_pkg::node_type               req_node_depth,
   input  lca_pkg::node_type               req_query_a,
   input  lca_pkg::node_type               req_query_b,
   input  lca_pkg::stat_type               stat,
   input  logic                            fifo_full,
   output logic                            push,
   output lca_pkg::cmd_type                cmd
);
   import lca_pkg::*;

   logic keep;

   // decode the function code; loads of the sentinel or out of range are dropped
   always_comb begin
      keep   = 1'b0;
      cmd.op = OP_LOAD;
      cmd.f0 = req_node;
      cmd.f1 = req_parent_node;
      cmd.f2 = req_node_depth;
      case (req_func)
         FUNC_LOAD: begin
            keep = (req_node != '0) && node_ok(req_node);
         end
         FUNC_BUILD: begin
            keep   = 1'b1;
            cmd.op = OP_BUILD;
         end
         FUNC_QUERY: begin
            keep   = 1'b1;
            cmd.op = OP_QUERY;
            cmd.f0 = req_query_a;
            cmd.f1 = req_query_b;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // no transaction is taken while the stores are cleared
   assign req_ready = !stat.clearing && !fifo_full;
   assign push      = req_valid && req_ready && keep;

endmodule

### hdl/lca_back.sv
// back end: sequencer for load, build and query over the ancestor and depth rams
// depends on lca_pkg and lca_ram
module lca_back (
   input  logic              clock,
   input  logic              reset,
   input  lca_pkg::cmd_type  cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  logic              csr_we,
   input  lca_pkg::node_type csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lca_pkg::node_type rsp_ancestor,
   output lca_pkg::stat_type stat
);
   import lca_pkg::*;

   state_type          state_ff, state_in;
   logic [TAB_AW-1:0]  clr_ff, clr_in;
   node_type           node_count_ff;
   node_type           a_ff, a_in;
   node_type           b_ff, b_in;
   node_type           da_ff, da_in;
   node_type           db_ff, db_in;
   node_type           pa_ff, pa_in;
   node_type           res_ff, res_in;
   node_type           i_ff, i_in;
   node_type           last_ff, last_in;
   lvl_type            lvl_ff, lvl_in;
   lvl_type            j_ff, j_in;
   logic               p_ok_ff, p_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   node_type           rsp_anc_ff, rsp_anc_in;

   logic               tab_we;
   logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
   node_type           tab_wdata, tab_rdata;
   logic               dep_we;
   logic [NODE_AW-1:0] dep_waddr, dep_raddr;
   node_type           dep_wdata, dep_rdata;

   logic signed [DIFF_W-1:0] diff;
   logic                     lift;
   node_type                 nb;

   // ancestor table, entry node*LEVELS+j
   lca_ram #(.WIDTH(FIELD_W), .DEPTH(TAB_DEPTH)) u_tab (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (tab_wdata),
      .raddr (tab_raddr),
      .rdata (tab_rdata)
   );

   // depth store
   lca_ram #(.WIDTH(FIELD_W), .DEPTH(NODES)) u_dep (
      .clock (clock),
      .we    (dep_we),
      .waddr (dep_waddr),
      .wdata (dep_wdata),
      .raddr (dep_raddr),
      .rdata (dep_rdata)
   );

   // depth difference test of the lifting phase
   always_comb begin
      diff = $signed({2'b00, db_ff}) - $signed({2'b00, da_ff});
      lift = !diff[DIFF_W-1] && (32'(diff[DIFF_W-2:0]) >= (32'd1 << lvl_ff));
   end

   // next state and ram controls
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      pa_in        = pa_ff;
      res_in       = res_ff;
      i_in         = i_ff;
      last_in      = last_ff;
      lvl_in       = lvl_ff;
      j_in         = j_ff;
      p_ok_in      = p_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_anc_in   = rsp_anc_ff;
      nb           = '0;
      cmd_pop      = 1'b0;
      tab_we       = 1'b0;
      tab_waddr    = '0;
      tab_wdata    = '0;
      tab_raddr    = '0;
      dep_we       = 1'b0;
      dep_waddr    = '0;
      dep_wdata    = '0;
      dep_raddr    = '0;

      // result transaction taken by the receiver
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // zero both stores after reset
         S_CLEAR: begin
            tab_we    = 1'b1;
            tab_waddr = clr_ff;
            dep_we    = (32'(clr_ff) < 32'(NODES));
            dep_waddr = clr_ff[NODE_AW-1:0];
            if (clr_ff == TAB_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + TAB_AW'(1);
            end
         end

         // take the next command
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_LOAD: begin
                     tab_we    = 1'b1;
                     tab_waddr = tab_addr(cmd.f0, '0);
                     tab_wdata = cmd.f1;
                     dep_we    = 1'b1;
                     dep_waddr = depth_addr(cmd.f0);
                     dep_wdata = cmd.f2;
                  end
                  OP_BUILD: begin
                     last_in = build_last(node_count_ff);
                     i_in    = FIELD_W'(1);
                     j_in    = LVL_W'(1);
                     if (build_last(node_count_ff) != '0) begin
                        state_in = S_B_RD0;
                     end
                  end
                  OP_QUERY: begin
                     a_in     = cmd.f0;
                     b_in     = cmd.f1;
                     state_in = S_Q_DA;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // build: read level j-1 of node i
         S_B_RD0: begin
            tab_raddr = tab_addr(i_ff, j_ff - LVL_W'(1));
            state_in  = S_B_RD1;
         end

         // build: read level j-1 of that ancestor
         S_B_RD1: begin
            p_ok_in   = node_ok(tab_rdata);
            tab_raddr = tab_addr(tab_rdata, j_ff - LVL_W'(1));
            state_in  = S_B_WR;
         end

         // build: write level j of node i and advance
         S_B_WR: begin
            tab_we    = 1'b1;
            tab_waddr = tab_addr(i_ff, j_ff);
            tab_wdata = p_ok_ff ? tab_rdata : '0;
            state_in  = S_B_RD0;
            if (i_ff == last_ff) begin
               i_in = FIELD_W'(1);
               if (j_ff == LVL_TOP) begin
                  state_in = S_IDLE;
               end else begin
                  j_in = j_ff + LVL_W'(1);
               end
            end else begin
               i_in = i_ff + FIELD_W'(1);
            end
         end

         // query: fetch both depths
         S_Q_DA: begin
            dep_raddr = depth_addr(a_ff);
            state_in  = S_Q_DB;
         end

         S_Q_DB: begin
            da_in     = node_ok(a_ff) ? dep_rdata : '0;
            dep_raddr = depth_addr(b_ff);
            state_in  = S_Q_SWAP;
         end

         // keep the deeper node in b
         S_Q_SWAP: begin
            nb = node_ok(b_ff) ? dep_rdata : '0;
            if (da_ff > nb) begin
               a_in  = b_ff;
               b_in  = a_ff;
               da_in = nb;
               db_in = da_ff;
            end else begin
               db_in = nb;
            end
            lvl_in   = LVL_TOP;
            state_in = S_L_CHK;
         end

         // lifting phase: test the depth difference at this level
         S_L_CHK: begin
            if (lift) begin
               tab_raddr = tab_addr(b_ff, lvl_ff);
               state_in  = S_L_UP;
            end else if (lvl_ff == '0) begin
               state_in = S_L_END;
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end

         // lift b and fetch its new depth
         S_L_UP: begin
            nb        = node_ok(b_ff) ? tab_rdata : '0;
            b_in      = nb;
            dep_raddr = depth_addr(nb);
            state_in  = S_L_DEP;
         end

         S_L_DEP: begin
            db_in = node_ok(b_ff) ? dep_rdata : '0;
            if (lvl_ff == '0) begin
               state_in = S_L_END;
            end else begin
               lvl_in   = lvl_ff - LVL_W'(1);
               state_in = S_L_CHK;
            end
         end

         // equal nodes end the query early
         S_L_END: begin
            if (a_ff == b_ff) begin
               res_in   = a_ff;
               state_in = S_Q_OUT;
            end else begin
               lvl_in   = LVL_TOP;
               state_in = S_M_RA;
            end
         end

         // joint phase: read both ancestors at this level
         S_M_RA: begin
            tab_raddr = tab_addr(a_ff, lvl_ff);
            state_in  = S_M_RB;
         end

         S_M_RB: begin
            pa_in     = node_ok(a_ff) ? tab_rdata : '0;
            tab_raddr = tab_addr(b_ff, lvl_ff);
            state_in  = S_M_CMP;
         end

         S_M_CMP: begin
            nb = node_ok(b_ff) ? tab_rdata : '0;
            if (pa_ff != nb) begin
               a_in = pa_ff;
               b_in = nb;
            end
            if (lvl_ff == '0) begin
               state_in = S_M_FIN;
            end else begin
               lvl_in   = lvl_ff - LVL_W'(1);
               state_in = S_M_RA;
            end
         end

         // answer is the direct parent of a
         S_M_FIN: begin
            tab_raddr = tab_addr(a_ff, '0);
            state_in  = S_M_RES;
         end

         S_M_RES: begin
            res_in   = node_ok(a_ff) ? tab_rdata : '0;
            state_in = S_Q_OUT;
         end

         // hand the answer to the output register once it is free
         S_Q_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_anc_in   = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      da_ff      <= da_in;
      db_ff      <= db_in;
      pa_ff      <= pa_in;
      res_ff     <= res_in;
      i_ff       <= i_in;
      last_ff    <= last_in;
      lvl_ff     <= lvl_in;
      j_ff       <= j_in;
      p_ok_ff    <= p_ok_in;
      rsp_anc_ff <= rsp_anc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ancestor  = rsp_anc_ff;
   assign stat.clearing = (state_ff == S_CLEAR);

endmodule

### hdl/lca_binary_lifting.sv
// top level of the lowest common ancestor engine using binary lifting
// depends on lca_pkg, lca_front, lca_fifo, lca_back and the assertion header
//
// usage
// - request channel (req_valid/req_ready): func 0 loads a node's parent and
//   depth, func 1 builds the 2^j ancestor table, func 2 queries the lowest
//   common ancestor of req_query_a and req_query_b; func 3 is taken and ignored
// - response channel (rsp_valid/rsp_ready): one transaction per query,
//   in request order, held in an output register
// - csr_we/csr_wdata write node_count, the highest node a build covers;
//   write only while the block is idle
// - a load writes both stores straight from idle; a build reads level j-1 of
//   each node and of its ancestor, then writes level j, for every node and
//   level; a query fetches and orders both depths, lifts the deeper node level
//   by level, runs the joint pass level by level and hands off the answer
// - a four-entry command queue separates the front from the back, so requests
//   keep being taken while a query runs or a response waits, until it is full
// - after reset both rams are zeroed, during which req_ready is low; node_count
//   resets to 1023
// - a stalled response holds the back end at the end of the next query only
module lca_binary_lifting (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [lca_pkg::FUNC_W-1:0] req_func,
   input  lca_pkg::node_type          req_node,
   input  lca_pkg::node_type          req_parent_node,
   input  lca_pkg::node_type          req_node_depth,
   input  lca_pkg::node_type          req_query_a,
   input  lca_pkg::node_type          req_query_b,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lca_pkg::node_type          rsp_ancestor,
   input  logic                       csr_we,
   input  lca_pkg::node_type          csr_wdata
);
   import lca_pkg::*;

`include "lca_binary_lifting_assert.svh"

   stat_type stat;
   cmd_type  push_cmd;
   cmd_type  head_cmd;
   logic     fifo_push;
   logic     fifo_pop;
   logic     fifo_full;
   logic     fifo_empty;

   // classify request transactions
   lca_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_node        (req_node),
      .req_parent_node (req_parent_node),
      .req_node_depth  (req_node_depth),
      .req_query_a     (req_query_a),
      .req_query_b     (req_query_b),
      .stat            (stat),
      .fifo_full       (fifo_full),
      .push            (fifo_push),
      .cmd             (push_cmd)
   );

   // command queue
   lca_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_cmd),
      .pop       (fifo_pop),
      .head      (head_cmd),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   // execute commands
   lca_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd          (head_cmd),
      .cmd_valid    (!fifo_empty),
      .cmd_pop      (fifo_pop),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_ancestor (rsp_ancestor),
      .stat         (stat)
   );

   // checks
   `LCA_ASSERT_NOW(a_no_accept_clear, clock, reset, stat.clearing, !req_ready)
   `LCA_ASSERT_NOW(a_push_room, clock, reset, fifo_push, !fifo_full)
   `LCA_ASSERT_NOW(a_pop_data, clock, reset, fifo_pop, !fifo_empty)
   `LCA_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), stat.clearing)

endmodule
